// ----- rtl/cgpg_pkg.sv -----
// Shared constants and controller/datapath interface types for the character generator.
`default_nettype none

package cgpg_pkg;

   // Field widths.
   localparam int FONT_ADDR_W   = 13;
   localparam int FONT_BYTE_W   = 8;
   localparam int CODE_W        = 8;
   localparam int GLYPH_CODE_W  = 7;
   localparam int X_W           = 9;
   localparam int Y_W           = 8;
   localparam int COLOR_W       = 16;
   localparam int FORMAT_W      = 4;
   localparam int COL_BASE_W    = 10;
   localparam int CHAR_COUNT_W  = 7;
   localparam int X_SUM_W       = 11;
   localparam int GLYPH_IDX_W   = 3;

   // Geometry and limits.
   localparam int FONT_PITCH    = 1024;
   localparam int FONT_DEPTH    = 8 * FONT_PITCH;
   localparam int SCREEN_WIDTH  = 320;
   localparam int SCREEN_HEIGHT = 240;
   localparam int MAX_CHARS     = 79;
   localparam int MAX_CODE      = 126;
   localparam int CHAR_ADVANCE  = 8;
   localparam int GLYPH_LAST    = 7;

   // Pixel format codes.
   localparam logic [FORMAT_W-1:0] FMT_WIDE   = 4'd12;
   localparam logic [FORMAT_W-1:0] FMT_NARROW = 4'd11;
   localparam logic [FORMAT_W-1:0] FMT_RESET  = FMT_WIDE;

   // Item function codes.
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_DRAW = 1'b1;

   // Register bus.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_INDEX_FORMAT = 1'b0;

   typedef struct packed {
      logic accept_load;
      logic accept_draw;
      logic prep_step;
      logic issue;
      logic flush;
   } ctrl_cmd_type;

   typedef struct packed {
      logic draw_go;
      logic prep_done;
      logic out_free;
      logic pos_last;
      logic pend_valid;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- rtl/cgpg_ctrl.sv -----
// Sequencing state machine for font loads and character scans.
`default_nettype none

module cgpg_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_func,
   output logic                        req_ready,
   input  wire cgpg_pkg::dp_status_type status,
   output cgpg_pkg::ctrl_cmd_type      cmd
);
   import cgpg_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SCAN,
      ST_DRAIN,
      ST_FLUSH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd             = '0;
      cmd.accept_load = accept && (req_func == FUNC_LOAD);
      cmd.accept_draw = accept && (req_func == FUNC_DRAW);
      cmd.prep_step   = (state_ff == ST_PREP);
      cmd.issue       = (state_ff == ST_SCAN) && status.out_free;
      cmd.flush       = (state_ff == ST_FLUSH) && status.pend_valid && status.out_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept_draw && status.draw_go) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (status.prep_done) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cmd.issue && status.pos_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The final font read is evaluated once the output side can move.
            if (status.out_free) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!status.pend_valid || status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/cgpg_datapath.sv -----
// Font blank map, string state, glyph scan counters and pixel output register.
`default_nettype none

module cgpg_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire cgpg_pkg::ctrl_cmd_type                cmd,
   output cgpg_pkg::dp_status_type                    status,
   input  wire logic [cgpg_pkg::FORMAT_W-1:0]         pixel_format,
   input  wire logic [cgpg_pkg::FONT_ADDR_W-1:0]      req_font_address,
   input  wire logic [cgpg_pkg::FONT_BYTE_W-1:0]      req_font_byte,
   input  wire logic [cgpg_pkg::CODE_W-1:0]           req_char_code,
   input  wire logic [cgpg_pkg::X_W-1:0]              req_origin_x,
   input  wire logic [cgpg_pkg::Y_W-1:0]              req_origin_y,
   input  wire logic [cgpg_pkg::COLOR_W-1:0]          req_ink_color,
   input  wire logic                                  req_string_start,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [cgpg_pkg::X_W-1:0]                   rsp_pixel_x,
   output logic [cgpg_pkg::Y_W-1:0]                   rsp_pixel_y,
   output logic [cgpg_pkg::COLOR_W-1:0]               rsp_pixel_value,
   output logic                                       rsp_wide_pixel,
   output logic                                       rsp_last
);
   import cgpg_pkg::*;

   // Font blank map: one bit per font byte, set when the byte was zero.
   logic font_mem [FONT_DEPTH];
   logic rd_data_ff;

   // String state.
   logic [COL_BASE_W-1:0]   col_base_ff;
   logic [CHAR_COUNT_W-1:0] char_count_ff;
   logic [COL_BASE_W-1:0]   col_base_eff;
   logic [CHAR_COUNT_W-1:0] char_count_eff;
   logic                    count_ok;
   logic                    format_ok;

   // Per-character operands.
   logic [GLYPH_CODE_W-1:0] code_ff;
   logic [COLOR_W-1:0]      value_ff;
   logic                    wide_ff;
   logic [Y_W-1:0]          y_base_ff;

   // Scan position, issue side.
   logic [GLYPH_IDX_W-1:0]  col_ff;
   logic [GLYPH_IDX_W-1:0]  row_ff;
   logic [X_SUM_W-1:0]      x_acc_ff;
   logic [Y_W-1:0]          y_cur_ff;
   logic [FONT_ADDR_W-1:0]  font_idx;

   // Position of the entry whose read data is in rd_data_ff.
   logic                    s1_valid_ff;
   logic [X_W-1:0]          s1_x_ff;
   logic [Y_W-1:0]          s1_y_ff;

   // One-deep hold of the latest blank pixel, so the final one can be tagged.
   logic                    pend_valid_ff;
   logic [X_W-1:0]          pend_x_ff;
   logic [Y_W-1:0]          pend_y_ff;

   logic                    out_free;
   logic                    eval;
   logic                    push;
   logic [X_SUM_W-1:0]      x_sum;
   logic [CODE_W-1:0]       code_clamped;

   assign out_free = !rsp_valid || rsp_ready;
   assign eval     = s1_valid_ff && out_free;
   assign push     = (eval && rd_data_ff && pend_valid_ff) || cmd.flush;

   assign col_base_eff   = req_string_start ? '0 : col_base_ff;
   assign char_count_eff = req_string_start ? '0 : char_count_ff;
   assign count_ok       = (char_count_eff < CHAR_COUNT_W'(MAX_CHARS));
   assign format_ok      = (pixel_format == FMT_WIDE) || (pixel_format == FMT_NARROW);
   assign x_sum          = X_SUM_W'(req_origin_x) + X_SUM_W'(col_base_eff);
   assign code_clamped   = (req_char_code > CODE_W'(MAX_CODE)) ? '0 : req_char_code;

   assign font_idx = FONT_ADDR_W'(row_ff) * FONT_ADDR_W'(FONT_PITCH)
                   + FONT_ADDR_W'({code_ff, 3'b000})
                   + FONT_ADDR_W'(col_ff);

   always_comb begin
      status            = '0;
      status.draw_go    = count_ok && format_ok;
      status.prep_done  = (x_acc_ff < X_SUM_W'(SCREEN_WIDTH));
      status.out_free   = out_free;
      status.pos_last   = (row_ff == GLYPH_IDX_W'(GLYPH_LAST))
                       && (col_ff == GLYPH_IDX_W'(GLYPH_LAST));
      status.pend_valid = pend_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept_load) begin
         font_mem[req_font_address] <= (req_font_byte == '0);
      end
      if (cmd.issue) begin
         rd_data_ff <= font_mem[font_idx];
      end
   end

   // String state: a character past the limit changes nothing.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_base_ff   <= '0;
         char_count_ff <= '0;
      end else if (cmd.accept_draw) begin
         if (count_ok) begin
            col_base_ff   <= col_base_eff + COL_BASE_W'(CHAR_ADVANCE);
            char_count_ff <= char_count_eff + 1'b1;
         end else begin
            col_base_ff   <= col_base_eff;
            char_count_ff <= char_count_eff;
         end
      end
   end

   // Operand capture, modulo reduction of the start column and scan stepping.
   always_ff @(posedge clock) begin
      if (cmd.accept_draw) begin
         code_ff   <= code_clamped[GLYPH_CODE_W-1:0];
         wide_ff   <= (pixel_format == FMT_WIDE);
         value_ff  <= (pixel_format == FMT_WIDE) ? req_ink_color
                                                 : {8'h00, req_ink_color[7:0]};
         y_base_ff <= (req_origin_y >= Y_W'(SCREEN_HEIGHT))
                    ? req_origin_y - Y_W'(SCREEN_HEIGHT) : req_origin_y;
         y_cur_ff  <= (req_origin_y >= Y_W'(SCREEN_HEIGHT))
                    ? req_origin_y - Y_W'(SCREEN_HEIGHT) : req_origin_y;
         x_acc_ff  <= x_sum;
         col_ff    <= '0;
         row_ff    <= '0;
      end else if (cmd.prep_step) begin
         if (x_acc_ff >= X_SUM_W'(SCREEN_WIDTH)) begin
            x_acc_ff <= x_acc_ff - X_SUM_W'(SCREEN_WIDTH);
         end
      end else if (cmd.issue) begin
         if (row_ff == GLYPH_IDX_W'(GLYPH_LAST)) begin
            row_ff   <= '0;
            col_ff   <= col_ff + 1'b1;
            y_cur_ff <= y_base_ff;
            x_acc_ff <= (x_acc_ff == X_SUM_W'(SCREEN_WIDTH - 1)) ? '0 : x_acc_ff + 1'b1;
         end else begin
            row_ff   <= row_ff + 1'b1;
            y_cur_ff <= (y_cur_ff == Y_W'(SCREEN_HEIGHT - 1)) ? '0 : y_cur_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (out_free) begin
         s1_valid_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         s1_x_ff <= x_acc_ff[X_W-1:0];
         s1_y_ff <= y_cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (eval && rd_data_ff) begin
         pend_valid_ff <= 1'b1;
      end else if (cmd.flush) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (eval && rd_data_ff) begin
         pend_x_ff <= s1_x_ff;
         pend_y_ff <= s1_y_ff;
      end
   end

   // Output register; a held pixel moves out when a newer one arrives or at the flush.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (push) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_pixel_x     <= pend_x_ff;
         rsp_pixel_y     <= pend_y_ff;
         rsp_pixel_value <= value_ff;
         rsp_wide_pixel  <= wide_ff;
         rsp_last        <= cmd.flush;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/char_glyph_pixel_generator_top.sv -----
// Top level of the 8x8 character generator: register port, controller and datapath.
`default_nettype none

// A load transaction (func 0) writes one font entry; the block keeps one bit per font byte,
// set when the byte is zero. A draw transaction (func 1) scans the 8x8 glyph column by
// column and emits one pixel transaction per blank font entry, with last set on the final
// one. From its acceptance until the next transaction can be accepted, a draw passes
// through the accepting cycle, the reduction of the start column modulo 320, the scan in
// which the single-port font map returns one entry per cycle while the result channel
// does not stall, and the drain that tags the final pixel; a stalled result channel holds
// the draw. A refused draw (character limit reached or pixel format other than 11 or 12)
// emits nothing and leaves the controller idle. The font map is not cleared after reset;
// entries must be loaded before they are drawn. lcd_pixel_format lies at byte address 0.
module char_glyph_pixel_generator_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic                                  req_func,
   input  wire logic [cgpg_pkg::FONT_ADDR_W-1:0]      req_font_address,
   input  wire logic [cgpg_pkg::FONT_BYTE_W-1:0]      req_font_byte,
   input  wire logic [cgpg_pkg::CODE_W-1:0]           req_char_code,
   input  wire logic [cgpg_pkg::X_W-1:0]              req_origin_x,
   input  wire logic [cgpg_pkg::Y_W-1:0]              req_origin_y,
   input  wire logic [cgpg_pkg::COLOR_W-1:0]          req_ink_color,
   input  wire logic                                  req_string_start,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [cgpg_pkg::X_W-1:0]                   rsp_pixel_x,
   output logic [cgpg_pkg::Y_W-1:0]                   rsp_pixel_y,
   output logic [cgpg_pkg::COLOR_W-1:0]               rsp_pixel_value,
   output logic                                       rsp_wide_pixel,
   output logic                                       rsp_last,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [cgpg_pkg::CSR_ADDR_W-1:0]       paddr,
   input  wire logic [cgpg_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [cgpg_pkg::CSR_DATA_W-1:0]            prdata,
   output logic                                       pready
);
   import cgpg_pkg::*;

   ctrl_cmd_type          cmd;
   dp_status_type         status;
   logic [FORMAT_W-1:0]   format_ff;
   logic                  csr_hit;

   assign pready  = 1'b1;
   assign csr_hit = (paddr[CSR_ADDR_W-1] == CSR_INDEX_FORMAT);
   assign prdata  = csr_hit ? CSR_DATA_W'(format_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= FMT_RESET;
      end else if (psel && penable && pwrite && pready && csr_hit) begin
         format_ff <= pwdata[FORMAT_W-1:0];
      end
   end

   cgpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cgpg_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .pixel_format     (format_ff),
      .req_font_address (req_font_address),
      .req_font_byte    (req_font_byte),
      .req_char_code    (req_char_code),
      .req_origin_x     (req_origin_x),
      .req_origin_y     (req_origin_y),
      .req_ink_color    (req_ink_color),
      .req_string_start (req_string_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_wide_pixel   (rsp_wide_pixel),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire
